/* rtl/core/aes128_cbc_block_decrypt_defines.svh */
// Assertion macros for the AES-128 CBC decrypt block.
`ifndef AES128_CBC_BLOCK_DECRYPT_DEFINES_SVH
`define AES128_CBC_BLOCK_DECRYPT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ACBC_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ACBC_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/core/acbc_pkg.sv */
// Package with AES inverse cipher types, tables and helper functions.
`default_nettype none
package acbc_pkg;
  localparam int RoundCount = 10;
  localparam int KeyWords = 4 * (RoundCount + 1);
  localparam int KeyAddrW = $clog2(KeyWords);
  localparam int RoundW = $clog2(RoundCount + 1);

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow = 2'd1;
  localparam logic [1:0] CfgIvHigh = 2'd2;
  localparam logic [1:0] CfgIvLow = 2'd3;

  typedef enum logic [2:0] {
    ST_EXPAND, ST_IDLE, ST_LOAD, ST_ROUND, ST_DONE
  } state_t;

  typedef struct packed {
    logic                busy;
    logic [KeyAddrW-1:0] addr;
  } ks_status_t;

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Forward S-box as the inverse of the table above.
  function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (InvSbox[i] == x) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction
endpackage
`default_nettype wire

/* rtl/core/acbc_key_sched.sv */
// Key expansion engine writing one round-key word per cycle into the key RAM.
`default_nettype none
module acbc_key_sched (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [127:0]                 key,
  output acbc_pkg::ks_status_t              status,
  output logic                              wr_en,
  output logic [31:0]                       wr_data
);
  import acbc_pkg::*;
  `include "aes128_cbc_block_decrypt_defines.svh"

  logic [31:0] win [4];
  logic [7:0]  rcon;
  logic [KeyAddrW-1:0] addr;
  logic        busy;
  logic [31:0] t, rot, sub;

  assign rot = {win[3][23:0], win[3][31:24]};
  always_comb begin
    sub = {fwd_sbox(rot[31:24]), fwd_sbox(rot[23:16]), fwd_sbox(rot[15:8]),
           fwd_sbox(rot[7:0])} ^ {rcon, 24'h0};
    t = (addr[1:0] == 2'd0) ? sub : win[3];
  end

  always_comb begin
    wr_en = busy;
    if (addr < KeyAddrW'(4)) wr_data = key[127 - 32*addr[1:0] -: 32];
    else wr_data = win[0] ^ t;
  end

  assign status.busy = busy;
  assign status.addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
      rcon <= 8'h01;
    end else if (start) begin
      busy <= 1'b1;
      addr <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= win[3];
      win[3] <= wr_data;
      if (addr >= KeyAddrW'(4) && addr[1:0] == 2'd0) rcon <= xtime(rcon);
      if (addr == KeyAddrW'(KeyWords - 1)) busy <= 1'b0;
      else addr <= addr + 1'b1;
    end
  end

  `ACBC_ASSERT_NXT(a_ks_addr_step, busy && !start && addr != KeyAddrW'(KeyWords-1),
                   addr == $past(addr) + 1'b1)
  `ACBC_ASSERT_IMP(a_ks_addr_range, busy, addr <= KeyAddrW'(KeyWords - 1))
  `ACBC_ASSERT_NXT(a_ks_start, start, busy && addr == '0)
endmodule
`default_nettype wire

/* rtl/core/acbc_round.sv */
// One inverse AES round as combinational logic: shift, sub, key add, optional mix.
`default_nettype none
module acbc_round (
  input  wire logic [127:0] state_in,
  input  wire logic [127:0] round_key,
  input  wire logic         do_mix,
  output logic [127:0]      state_out
);
  import acbc_pkg::*;

  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc, x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc ^= x;
      x = xtime(x);
    end
    return acc;
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[4*((c + r) % 4) + r] = InvSbox[s[4*c + r]];
      end
    end
    // The round key is added after the bytes have moved to their new columns.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = sh[4*c + r] ^ round_key[127 - 32*c - 8*r -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = gm(t[4*c],4'he)^gm(t[4*c+1],4'hb)^gm(t[4*c+2],4'hd)^gm(t[4*c+3],4'h9);
      m[4*c+1] = gm(t[4*c],4'h9)^gm(t[4*c+1],4'he)^gm(t[4*c+2],4'hb)^gm(t[4*c+3],4'hd);
      m[4*c+2] = gm(t[4*c],4'hd)^gm(t[4*c+1],4'h9)^gm(t[4*c+2],4'he)^gm(t[4*c+3],4'hb);
      m[4*c+3] = gm(t[4*c],4'hb)^gm(t[4*c+1],4'hd)^gm(t[4*c+2],4'h9)^gm(t[4*c+3],4'he);
    end
    for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = do_mix ? m[i] : t[i];
  end
endmodule
`default_nettype wire

/* rtl/core/aes128_cbc_block_decrypt.sv */
// Top level of the AES-128 CBC decryption block with key RAM and round sequencer.
// The block reads four key words and adds the first round key, then runs ten rounds
// that each read four key words; only one block is in flight, and a new input beat
// is accepted only after the output beat is taken and the sequencer is back in idle.
// Reset clears the key and IV to zero and expands the all-zero key, during which no
// input beat is accepted; a key write does the same.
`default_nettype none
module aes128_cbc_block_decrypt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // cipher_high, cipher_low
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // plain_high, plain_low
  output logic              m_axis_tlast
);
  import acbc_pkg::*;
  `include "aes128_cbc_block_decrypt_defines.svh"

  // Lower tdata half is the first field, so cipher_high sits in bits 63:0.
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [127:0] chain, cipher, st, st_next;
  logic         last;
  state_t       state, state_next;
  logic [RoundW-1:0] rnd;
  logic [1:0]   wsel;
  logic         ks_start;
  ks_status_t   ks;
  logic         ks_wr;
  logic [31:0]  ks_data;

  // Key RAM: the 44 schedule words of 32 bits; the four words of a round are
  // read one per cycle and the first three are held until the fourth arrives.
  logic [31:0]  key_ram [KeyWords];
  logic [KeyAddrW-1:0] rd_addr;
  logic [127:0] rk;
  logic [31:0]  rd_word;
  logic [95:0]  rk_hold;

  // Each round: the four words are read through the registered RAM port, then applied.
  logic [2:0] phase;

  logic cfg_fire, in_fire, out_fire;
  // Registers change only while no block is in flight.
  assign cfg_ready = (state == ST_IDLE) || (state == ST_EXPAND);
  assign cfg_fire = cfg_valid && cfg_ready;
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == ST_DONE);
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign ks_start = cfg_fire && (cfg_index == CfgKeyHigh || cfg_index == CfgKeyLow);

  // The engine reads the key words in the cycles after the start, when the
  // key registers already hold the written half.
  acbc_key_sched u_ks (
    .clk(clk), .rst(rst), .start(ks_start),
    .key({key_high, key_low}),
    .status(ks), .wr_en(ks_wr), .wr_data(ks_data)
  );

  always_ff @(posedge clk) begin
    if (ks_wr) key_ram[ks.addr] <= ks_data;
    rd_word <= key_ram[rd_addr];
  end

  assign rd_addr = KeyAddrW'({rnd, wsel});
  assign rk = {rk_hold, rd_word};

  acbc_round u_round (
    .state_in(st), .round_key(rk), .do_mix(rnd != '0), .state_out(st_next)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EXPAND: if (!ks.busy && !ks_start) state_next = ST_IDLE;
      ST_IDLE:   if (ks_start) state_next = ST_EXPAND;
                 else if (in_fire) state_next = ST_LOAD;
      ST_LOAD:   if (phase == 3'd4) state_next = ST_ROUND;
      ST_ROUND:  if (phase == 3'd4 && rnd == '0) state_next = ST_DONE;
      ST_DONE:   if (out_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    m_axis_tdata = {st[63:0] ^ chain[63:0], st[127:64] ^ chain[127:64]};
    m_axis_tlast = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXPAND;
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      chain <= '0;
      rnd <= RoundW'(RoundCount);
      wsel <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        unique case (cfg_index)
          CfgKeyHigh: key_high <= cfg_data;
          CfgKeyLow:  key_low <= cfg_data;
          CfgIvHigh: begin iv_high <= cfg_data; chain <= {cfg_data, iv_low}; end
          CfgIvLow:  begin iv_low <= cfg_data; chain <= {iv_high, cfg_data}; end
          default: ;
        endcase
      end
      if (in_fire) begin
        cipher <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        st <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        last <= s_axis_tlast;
        rnd <= RoundW'(RoundCount);
        wsel <= '0;
        phase <= '0;
      end
      if (state == ST_LOAD || state == ST_ROUND) begin
        if (phase == 3'd1) rk_hold[95:64] <= rd_word;
        if (phase == 3'd2) rk_hold[63:32] <= rd_word;
        if (phase == 3'd3) rk_hold[31:0] <= rd_word;
        if (phase < 3'd3) wsel <= wsel + 1'b1;
        if (phase == 3'd4) begin
          phase <= '0;
          wsel <= '0;
          if (state == ST_LOAD) begin
            st <= st ^ rk;
            rnd <= rnd - 1'b1;
          end else begin
            st <= st_next;
            if (rnd != '0) rnd <= rnd - 1'b1;
          end
        end else phase <= phase + 1'b1;
      end
      if (out_fire) chain <= last ? {iv_high, iv_low} : cipher;
    end
  end

  `ACBC_ASSERT_IMP(a_no_in_busy, s_axis_tready, state == ST_IDLE)
  `ACBC_ASSERT_NXT(a_done_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ACBC_ASSERT_IMP(a_out_idle_ks, m_axis_tvalid, !ks.busy)
endmodule
`default_nettype wire
